FILE: design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants, sector codes and the stage bundle for the hsv to rgb pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int unsigned HUE_W   = 16;
	localparam int unsigned FIX_W   = 9;
	localparam int unsigned CHAN_W  = 8;

	// six full turns of 5760 lifts any 16-bit hue above zero
	localparam logic [17:0] HUE_LIFT = 18'd34560;
	// 65535 / 15, reciprocal for division by fifteen
	localparam logic [12:0] INV15    = 13'd4369;
	// (q * 43) >> 8 equals q / 6 for q below 128
	localparam logic [5:0]  INV6     = 6'd43;
	localparam logic [8:0]  ONE_FIX  = 9'd256;
	localparam logic [7:0]  CHAN_SCALE = 8'd255;
	localparam logic [3:0]  FIFTEEN  = 4'd15;
	localparam logic [9:0]  SECTOR_SPAN = 10'd960;

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	// hue front end to mixing back end
	typedef struct packed {
		logic              vld;
		sector_t           sector;
		logic [11:0]       y;       // in-sector remainder times four
		logic [7:0]        f0;      // estimate of y / 15, may be one low
		logic [FIX_W-1:0]  s;
		logic [FIX_W-1:0]  v;
	} frac_t;

endpackage

FILE: design/hsv2rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb interfaces
// valid/ready channels for hsv input items and rgb result items
// ----------------------------------------------------------------------------
interface hsv_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hsv2rgb_pkg::HUE_W-1:0] hue;
	logic [hsv2rgb_pkg::FIX_W-1:0]        saturation;
	logic [hsv2rgb_pkg::FIX_W-1:0]        brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_if;
	logic                           valid;
	logic                           ready;
	logic [hsv2rgb_pkg::CHAN_W-1:0] red;
	logic [hsv2rgb_pkg::CHAN_W-1:0] green;
	logic [hsv2rgb_pkg::CHAN_W-1:0] blue_out;

	modport source (output valid, red, green, blue_out, input ready);
	modport sink   (input valid, red, green, blue_out, output ready);
endinterface

FILE: design/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue (signed, 1/16 degree), saturation and brightness (8 fraction
// bits, 256 is 1.0, larger values clamp) to 8-bit red, green and blue. The
// block is a six-stage pipeline: a transaction accepted on hsv passes each
// stage register in turn to reach rgb, and one transaction per cycle streams
// through without gaps while rgb takes every result. Stalls on rgb hold the
// whole pipeline; hsv.ready is high whenever the last stage is empty or rgb
// is taking its result, so a new transaction can enter in the same cycle that
// rgb takes a finished one, while a finished one that waits holds hsv off.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic         clk,
	input  logic         arst_n,
	hsv_if.sink          hsv,
	rgb_if.source        rgb
);

	logic               en;
	logic               vld_out;
	hsv2rgb_pkg::frac_t frac;

	// the pipeline moves when the output stage is empty or being drained
	assign en        = !vld_out || rgb.ready;
	assign hsv.ready = en;
	assign rgb.valid = vld_out;

	hsv2rgb_hue u_hue (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (hsv.valid),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.frac       (frac)
	);

	hsv2rgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.frac     (frac),
		.vld      (vld_out),
		.red      (rgb.red),
		.green    (rgb.green),
		.blue_out (rgb.blue_out)
	);

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb.valid |-> hsv.ready)
		else $error("input blocked with empty output stage");

	a_stall_holds_frac: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(frac))
		else $error("pipeline advanced during stall");

	// an accepted transaction reaches the front end output after two more moves
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv.valid && hsv.ready) ##1 en ##1 en |=> frac.vld)
		else $error("accepted transaction lost in front end");

endmodule

FILE: design/hsv2rgb_hue.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue
// stages 1 to 3: hue wrap, sector and in-sector remainder, clamps, ff estimate
// ----------------------------------------------------------------------------
module hsv2rgb_hue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_vld,
	input  logic signed [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  logic [hsv2rgb_pkg::FIX_W-1:0]        saturation,
	input  logic [hsv2rgb_pkg::FIX_W-1:0]        brightness,
	output hsv2rgb_pkg::frac_t                   frac
);

	// stage 1
	logic [17:0] lifted;
	logic [23:0] x_prod;
	logic [8:0]  s_clamp, v_clamp;

	logic        vld_s1;
	logic [10:0] x_s1;
	logic [6:0]  q0_s1;
	logic [5:0]  low_s1;
	logic [8:0]  s_s1, v_s1;

	// stage 2
	logic [10:0] q15;
	logic [10:0] r_raw;
	logic [6:0]  q_fix;
	logic [10:0] r_fix;
	logic [12:0] q6_prod;
	logic [6:0]  q6x6;
	logic [6:0]  sect_raw;

	logic        vld_s2;
	logic [9:0]  rem_s2;
	logic [2:0]  sector_s2;
	logic [8:0]  s_s2, v_s2;

	// stage 3
	logic [11:0] y_c;
	logic [24:0] y_prod;

	logic        vld_s3;
	logic [11:0] y_s3;
	logic [7:0]  f0_s3;
	logic [2:0]  sector_s3;
	logic [8:0]  s_s3, v_s3;

	always_comb begin
		lifted  = {{2{hue[15]}}, hue} + hsv2rgb_pkg::HUE_LIFT;
		x_prod  = 24'(lifted[16:6] * hsv2rgb_pkg::INV15);
		s_clamp = (saturation > hsv2rgb_pkg::ONE_FIX) ? hsv2rgb_pkg::ONE_FIX : saturation;
		v_clamp = (brightness > hsv2rgb_pkg::ONE_FIX) ? hsv2rgb_pkg::ONE_FIX : brightness;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= lifted[16:6];
			q0_s1  <= x_prod[22:16];
			low_s1 <= lifted[5:0];
			s_s1   <= s_clamp;
			v_s1   <= v_clamp;
		end
	end

	// quotient by 960 is (lifted >> 6) / 15, estimate may be one low
	always_comb begin
		q15   = {q0_s1, 4'b0} - {4'b0, q0_s1};
		r_raw = x_s1 - q15;
		if (r_raw >= 11'(hsv2rgb_pkg::FIFTEEN)) begin
			q_fix = q0_s1 + 7'd1;
			r_fix = r_raw - 11'(hsv2rgb_pkg::FIFTEEN);
		end else begin
			q_fix = q0_s1;
			r_fix = r_raw;
		end
		q6_prod  = 13'(q_fix * hsv2rgb_pkg::INV6);
		q6x6     = 7'({q6_prod[12:8], 2'b0}) + 7'({q6_prod[12:8], 1'b0});
		sect_raw = q_fix - q6x6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2    <= {r_fix[3:0], low_s1};
			sector_s2 <= sect_raw[2:0];
			s_s2      <= s_s1;
			v_s2      <= v_s1;
		end
	end

	// ff = rem * 256 / 960 = (rem * 4) / 15
	always_comb begin
		y_c    = {rem_s2, 2'b0};
		y_prod = 25'(y_c * hsv2rgb_pkg::INV15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3      <= y_c;
			f0_s3     <= y_prod[23:16];
			sector_s3 <= sector_s2;
			s_s3      <= s_s2;
			v_s3      <= v_s2;
		end
	end

	assign frac.vld    = vld_s3;
	assign frac.sector = hsv2rgb_pkg::sector_t'(sector_s3);
	assign frac.y      = y_s3;
	assign frac.f0     = f0_s3;
	assign frac.s      = s_s3;
	assign frac.v      = v_s3;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> rem_s2 < hsv2rgb_pkg::SECTOR_SPAN)
		else $error("in-sector remainder out of range");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> sector_s2 <= 3'(hsv2rgb_pkg::SEC_M_R))
		else $error("sector code out of range");

	a_ff_estimate_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (12'({f0_s3, 4'b0}) - 12'(f0_s3)) <= y_s3)
		else $error("ff estimate above exact quotient");

endmodule

FILE: design/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// stages 4 to 6: ff fix-up, p/q/t terms, sector routing, scale to 8 bits
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  hsv2rgb_pkg::frac_t             frac,
	output logic                           vld,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] blue_out
);

	// stage 4
	logic [11:0] f15;
	logic [11:0] ry;
	logic [7:0]  ff;
	logic [8:0]  ff_inv;
	logic [16:0] sf_prod, st_prod;

	logic                 vld_s4;
	logic [7:0]           sf_s4;
	logic [8:0]           st_s4;
	hsv2rgb_pkg::sector_t sector_s4;
	logic [8:0]           s_s4, v_s4;

	// stage 5
	logic [17:0] p_prod, q_prod, t_prod;
	logic [8:0]  p_t, q_t, t_t;
	logic [8:0]  r_t, g_t, b_t;

	logic       vld_s5;
	logic [8:0] r_s5, g_s5, b_s5;

	// stage 6
	logic [16:0] r_sc, g_sc, b_sc;

	logic       vld_s6;
	logic [7:0] red_s6, green_s6, blue_s6;

	always_comb begin
		f15     = 12'({frac.f0, 4'b0}) - 12'(frac.f0);
		ry      = frac.y - f15;
		ff      = (ry >= 12'(hsv2rgb_pkg::FIFTEEN)) ? frac.f0 + 8'd1 : frac.f0;
		ff_inv  = hsv2rgb_pkg::ONE_FIX - 9'(ff);
		sf_prod = 17'(frac.s * ff);
		st_prod = 17'(frac.s * ff_inv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= frac.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sf_s4     <= sf_prod[15:8];
			st_s4     <= st_prod[16:8];
			sector_s4 <= frac.sector;
			s_s4      <= frac.s;
			v_s4      <= frac.v;
		end
	end

	// zero saturation makes p, q and t all equal to v, which is the grey case
	always_comb begin
		p_prod = 18'(v_s4 * (hsv2rgb_pkg::ONE_FIX - s_s4));
		q_prod = 18'(v_s4 * (hsv2rgb_pkg::ONE_FIX - 9'(sf_s4)));
		t_prod = 18'(v_s4 * (hsv2rgb_pkg::ONE_FIX - st_s4));
		p_t    = p_prod[16:8];
		q_t    = q_prod[16:8];
		t_t    = t_prod[16:8];
		case (sector_s4)
			hsv2rgb_pkg::SEC_R_Y: begin r_t = v_s4; g_t = t_t;  b_t = p_t;  end
			hsv2rgb_pkg::SEC_Y_G: begin r_t = q_t;  g_t = v_s4; b_t = p_t;  end
			hsv2rgb_pkg::SEC_G_C: begin r_t = p_t;  g_t = v_s4; b_t = t_t;  end
			hsv2rgb_pkg::SEC_C_B: begin r_t = p_t;  g_t = q_t;  b_t = v_s4; end
			hsv2rgb_pkg::SEC_B_M: begin r_t = t_t;  g_t = p_t;  b_t = v_s4; end
			default:              begin r_t = v_s4; g_t = p_t;  b_t = q_t;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s5 <= r_t;
			g_s5 <= g_t;
			b_s5 <= b_t;
		end
	end

	always_comb begin
		r_sc = 17'(r_s5 * hsv2rgb_pkg::CHAN_SCALE);
		g_sc = 17'(g_s5 * hsv2rgb_pkg::CHAN_SCALE);
		b_sc = 17'(b_s5 * hsv2rgb_pkg::CHAN_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s6   <= r_sc[15:8];
			green_s6 <= g_sc[15:8];
			blue_s6  <= b_sc[15:8];
		end
	end

	assign vld      = vld_s6;
	assign red      = red_s6;
	assign green    = green_s6;
	assign blue_out = blue_s6;

	a_ff_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		frac.vld |-> (ry - (ry >= 12'(hsv2rgb_pkg::FIFTEEN) ? 12'(hsv2rgb_pkg::FIFTEEN) : 12'd0))
			< 12'(hsv2rgb_pkg::FIFTEEN))
		else $error("ff off by more than one");

	a_grey_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && s_s4 == 9'd0) |-> (sf_s4 == 8'd0 && st_s4 == 9'd0))
		else $error("zero saturation produced nonzero hue terms");

	a_terms_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (r_s5 <= hsv2rgb_pkg::ONE_FIX && g_s5 <= hsv2rgb_pkg::ONE_FIX
			&& b_s5 <= hsv2rgb_pkg::ONE_FIX))
		else $error("channel term above one");

endmodule
